@@ sv/ptwbb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-type window byte budget package
// Shared constants, action codes and the per-type table entry layout.
// ----------------------------------------------------------------------------
package ptwbb_pkg;

   localparam int TYPE_COUNT_DEFAULT = 64;
   localparam int TYPE_W             = 6;
   localparam int TIME_W             = 32;
   localparam int SIZE_W             = 16;
   localparam int COUNT_W            = 32;

   localparam logic [SIZE_W-1:0]  BUDGET_RESET = 16'd2048;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;

   localparam logic ACTION_MESSAGE = 1'b0;
   localparam logic ACTION_REPORT  = 1'b1;

   typedef struct packed {
      logic [SIZE_W-1:0]  remaining;
      logic [COUNT_W-1:0] accepted;
      logic [COUNT_W-1:0] windows;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] value);
      sat_inc = (value == COUNT_MAX) ? value : value + 1'b1;
   endfunction

endpackage

@@ sv/ptwbb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptwbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/per_type_window_byte_budget.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-type window byte budget
// Charges message sizes against per-type byte budgets over time windows and
// reports per-type average accepted messages per active window.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. With
// req_action at message, the block reads the type's table entry in the RAM
// and writes it back in the following cycle, and the next transaction may
// start right after. With req_action at report, the block scans the types
// in ascending order up to the last seen one; each seen type adds a RAM
// read in ST_LOAD and, when it has windows, a pass through the shared
// restoring divider in ST_DIV, and busy stays high while the report runs.
// Each result stands on the rsp_ ports for one cycle with rsp_valid high,
// and rsp_last marks the final line; the receiver cannot stall, so results
// are never held. A report with no seen type gives no result line.
// The csr_ channel writes budget_bytes and is always ready; before the first
// message it also reloads the budgets. Reset clears all flags and
// restores the budget to 2048; the counts in the table RAM need no clearing
// pass because per-type flags decide whether an entry holds data.
// ----------------------------------------------------------------------------
module per_type_window_byte_budget #(
   parameter int TYPE_COUNT = ptwbb_pkg::TYPE_COUNT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_action,
   input  logic [ptwbb_pkg::TIME_W-1:0]     req_msg_time,
   input  logic [ptwbb_pkg::TYPE_W-1:0]     req_msg_type,
   input  logic [ptwbb_pkg::SIZE_W-1:0]     req_msg_size,
   output logic                             rsp_valid,
   output logic [ptwbb_pkg::TYPE_W-1:0]     rsp_type_id,
   output logic [ptwbb_pkg::COUNT_W-1:0]    rsp_average,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ptwbb_pkg::SIZE_W-1:0]     csr_budget_bytes
);

   localparam int IDX_W     = $clog2(TYPE_COUNT);
   localparam int DIV_STEPS = ptwbb_pkg::COUNT_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MSG,
      ST_SCAN,
      ST_LOAD,
      ST_DIV
   } state_type;

   state_type                       state_ff, state_in;
   logic [ptwbb_pkg::SIZE_W-1:0]    budget_ff, budget_in;
   logic [ptwbb_pkg::SIZE_W-1:0]    win_budget_ff, win_budget_in;
   logic                            started_ff, started_in;
   logic [ptwbb_pkg::TIME_W-1:0]    window_time_ff, window_time_in;
   logic [TYPE_COUNT-1:0]           seen_ff, seen_in;
   logic [TYPE_COUNT-1:0]           used_ff, used_in;
   logic [ptwbb_pkg::TIME_W-1:0]    item_time_ff, item_time_in;
   logic [ptwbb_pkg::TYPE_W-1:0]    item_type_ff, item_type_in;
   logic [ptwbb_pkg::SIZE_W-1:0]    item_size_ff, item_size_in;
   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic [ptwbb_pkg::COUNT_W-1:0]   div_rem_ff, div_rem_in;
   logic [ptwbb_pkg::COUNT_W-1:0]   div_quo_ff, div_quo_in;
   logic [ptwbb_pkg::COUNT_W-1:0]   divisor_ff, divisor_in;
   logic [STEP_W-1:0]               step_ff, step_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ptwbb_pkg::TYPE_W-1:0]    rsp_type_ff, rsp_type_in;
   logic [ptwbb_pkg::COUNT_W-1:0]   rsp_avg_ff, rsp_avg_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic                            ram_we;
   logic [IDX_W-1:0]                ram_raddr;
   ptwbb_pkg::entry_type            rd_entry, wr_entry;
   logic [ptwbb_pkg::ENTRY_W-1:0]   ram_rdata;

   logic                            accept;
   logic                            in_range;
   logic                            refill;
   logic [IDX_W-1:0]                ty;
   logic                            used_eff;
   logic [ptwbb_pkg::SIZE_W-1:0]    rem_eff;
   logic [ptwbb_pkg::COUNT_W-1:0]   acc_eff, win_eff;
   logic                            fits;
   logic [TYPE_COUNT-1:0]           above;
   logic                            last_now;
   logic [ptwbb_pkg::COUNT_W:0]     shifted;
   logic                            div_ge;
   logic [ptwbb_pkg::COUNT_W-1:0]   div_rem_next, div_quo_next;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign ram_raddr = (state_ff == ST_IDLE) ? req_msg_type[IDX_W-1:0] : idx_ff;
   assign rd_entry  = ram_rdata;

   ptwbb_ram #(
      .WIDTH (ptwbb_pkg::ENTRY_W),
      .DEPTH (TYPE_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ty),
      .wr_data (wr_entry),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      in_range = ({1'b0, item_type_ff} < 7'(TYPE_COUNT));
      refill   = started_ff && (item_time_ff > window_time_ff);
      ty       = item_type_ff[IDX_W-1:0];
      used_eff = !refill && used_ff[ty];
      if (used_eff) begin
         rem_eff = rd_entry.remaining;
      end else begin
         rem_eff = refill ? budget_ff : win_budget_ff;
      end
      acc_eff = seen_ff[ty] ? rd_entry.accepted : '0;
      win_eff = seen_ff[ty] ? rd_entry.windows : '0;
      fits    = (item_size_ff <= rem_eff);
      wr_entry.remaining = fits ? rem_eff - item_size_ff : rem_eff;
      wr_entry.accepted  = fits ? ptwbb_pkg::sat_inc(acc_eff) : acc_eff;
      wr_entry.windows   = (fits && !used_eff) ? ptwbb_pkg::sat_inc(win_eff) : win_eff;
   end

   always_comb begin
      for (int i = 0; i < TYPE_COUNT; i++) begin
         above[i] = (i > int'(idx_ff));
      end
      last_now = ~|(seen_ff & above);
   end

   always_comb begin
      shifted      = {div_rem_ff, div_quo_ff[ptwbb_pkg::COUNT_W-1]};
      div_ge       = (shifted >= {1'b0, divisor_ff});
      div_rem_next = div_ge ? ptwbb_pkg::COUNT_W'(shifted - {1'b0, divisor_ff})
                            : shifted[ptwbb_pkg::COUNT_W-1:0];
      div_quo_next = {div_quo_ff[ptwbb_pkg::COUNT_W-2:0], div_ge};
   end

   always_comb begin
      state_in       = state_ff;
      budget_in      = budget_ff;
      win_budget_in  = win_budget_ff;
      started_in     = started_ff;
      window_time_in = window_time_ff;
      seen_in        = seen_ff;
      used_in        = used_ff;
      item_time_in   = item_time_ff;
      item_type_in   = item_type_ff;
      item_size_in   = item_size_ff;
      idx_in         = idx_ff;
      div_rem_in     = div_rem_ff;
      div_quo_in     = div_quo_ff;
      divisor_in     = divisor_ff;
      step_in        = step_ff;
      rsp_valid_in   = 1'b0;
      rsp_type_in    = rsp_type_ff;
      rsp_avg_in     = rsp_avg_ff;
      rsp_last_in    = rsp_last_ff;
      ram_we         = 1'b0;

      if (csr_valid) begin
         budget_in = csr_budget_bytes;
         if (!started_ff) begin
            win_budget_in = csr_budget_bytes;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_time_in = req_msg_time;
               item_type_in = req_msg_type;
               item_size_in = req_msg_size;
               idx_in       = '0;
               state_in     = (req_action == ptwbb_pkg::ACTION_REPORT) ? ST_SCAN : ST_MSG;
            end
         end
         ST_MSG: begin
            state_in = ST_IDLE;
            if (in_range) begin
               ram_we     = 1'b1;
               started_in = 1'b1;
               if (!started_ff || refill) begin
                  window_time_in = item_time_ff;
               end
               if (refill) begin
                  used_in       = '0;
                  win_budget_in = budget_ff;
               end
               used_in[ty] = used_in[ty] | fits;
               seen_in[ty] = 1'b1;
            end
         end
         ST_SCAN: begin
            if (seen_ff[idx_ff]) begin
               state_in = ST_LOAD;
            end else if (idx_ff == IDX_W'(TYPE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_LOAD: begin
            if (rd_entry.windows == '0) begin
               rsp_valid_in = 1'b1;
               rsp_type_in  = ptwbb_pkg::TYPE_W'(idx_ff);
               rsp_avg_in   = '0;
               rsp_last_in  = last_now;
               idx_in       = idx_ff + 1'b1;
               state_in     = last_now ? ST_IDLE : ST_SCAN;
            end else begin
               divisor_in = rd_entry.windows;
               div_quo_in = rd_entry.accepted;
               div_rem_in = '0;
               step_in    = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            div_rem_in = div_rem_next;
            div_quo_in = div_quo_next;
            step_in    = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               rsp_valid_in = 1'b1;
               rsp_type_in  = ptwbb_pkg::TYPE_W'(idx_ff);
               rsp_avg_in   = div_quo_next;
               rsp_last_in  = last_now;
               idx_in       = idx_ff + 1'b1;
               state_in     = last_now ? ST_IDLE : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         budget_ff      <= ptwbb_pkg::BUDGET_RESET;
         win_budget_ff  <= ptwbb_pkg::BUDGET_RESET;
         started_ff     <= 1'b0;
         window_time_ff <= '0;
         seen_ff        <= '0;
         used_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         budget_ff      <= budget_in;
         win_budget_ff  <= win_budget_in;
         started_ff     <= started_in;
         window_time_ff <= window_time_in;
         seen_ff        <= seen_in;
         used_ff        <= used_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      item_time_ff <= item_time_in;
      item_type_ff <= item_type_in;
      item_size_ff <= item_size_in;
      idx_ff       <= idx_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      divisor_ff   <= divisor_in;
      step_ff      <= step_in;
      rsp_type_ff  <= rsp_type_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_type_id = rsp_type_ff;
   assign rsp_average = rsp_avg_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

@@ sv/ptwbb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-type window byte budget checker
// Port-level assertions on command and result sequencing, bound to the top.
// ----------------------------------------------------------------------------
module ptwbb_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_action,
   input logic rsp_valid,
   input logic rsp_last
);

   logic msg_accept;

   assign msg_accept = start && !busy && (req_action == ptwbb_pkg::ACTION_MESSAGE);

   // A message transaction keeps the block busy after it is accepted.
   assert property (@(posedge clock) disable iff (reset) msg_accept |=> busy)
      else $error("busy did not rise after a message transaction");

   // A message transaction never produces results.
   assert property (@(posedge clock) disable iff (reset)
      msg_accept |=> !rsp_valid ##1 !rsp_valid)
      else $error("result after a message transaction");

   // Results never come in consecutive cycles.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("back-to-back results");

   // The final line of a report leaves the block free.
   assert property (@(posedge clock) disable iff (reset) rsp_valid && rsp_last |-> !busy)
      else $error("busy while the final report line is shown");

   // A line that is not the final one keeps the report running.
   assert property (@(posedge clock) disable iff (reset) rsp_valid && !rsp_last |=> busy)
      else $error("report ended without a final line");

endmodule

bind per_type_window_byte_budget ptwbb_checker u_ptwbb_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the per-type window byte budget
// Two directed tables around random transactions drive messages and reports
// into the block. A predictor in the bench tracks windows, budgets and counts
// and queues the report lines it expects, and every line the block emits is
// compared field by field with the oldest line in that queue. The budget
// register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NTYPES      = ptwbb_pkg::TYPE_COUNT_DEFAULT;
   localparam int TYPE_W      = ptwbb_pkg::TYPE_W;
   localparam int TIME_W      = ptwbb_pkg::TIME_W;
   localparam int SIZE_W      = ptwbb_pkg::SIZE_W;
   localparam int COUNT_W     = ptwbb_pkg::COUNT_W;
   localparam int SETTLE      = 100;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [TYPE_W-1:0]  type_id;
      logic [COUNT_W-1:0] average;
      logic               last;
   } line_type;

   typedef struct packed {
      logic               action;
      logic [TIME_W-1:0]  msg_time;
      logic [TYPE_W-1:0]  msg_type;
      logic [SIZE_W-1:0]  msg_size;
      bit                 typed;
      bit   [6:0]         lines;
      logic [TYPE_W-1:0]  line_type;
      logic [COUNT_W-1:0] line_average;
   } row_type;

   logic                clock;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic                busy;
   logic                req_action       = ptwbb_pkg::ACTION_MESSAGE;
   logic [TIME_W-1:0]   req_msg_time     = '0;
   logic [TYPE_W-1:0]   req_msg_type     = '0;
   logic [SIZE_W-1:0]   req_msg_size     = '0;
   logic                rsp_valid;
   logic [TYPE_W-1:0]   rsp_type_id;
   logic [COUNT_W-1:0]  rsp_average;
   logic                rsp_last;
   logic                csr_valid        = 1'b0;
   logic                csr_ready;
   logic [SIZE_W-1:0]   csr_budget_bytes = '0;

   logic [SIZE_W-1:0]   budget = ptwbb_pkg::BUDGET_RESET;
   logic [TIME_W-1:0]   window_start = '0;
   logic                window_open = 1'b0;
   logic                seen_type [NTYPES];
   logic [SIZE_W-1:0]   bytes_left [NTYPES];
   logic                used_in_window [NTYPES];
   logic [COUNT_W-1:0]  accepted_msgs [NTYPES];
   logic [COUNT_W-1:0]  active_windows [NTYPES];

   line_type            report_lines_due [$];
   int                  mismatches = 0;
   int                  cycle_count = 0;
   int                  idle_pct = 0;

   logic [SIZE_W-1:0]   segment_budget [6] =
      '{16'hFFFF, 16'd0, 16'd1200, 16'd2048, 16'd1, 16'd3000};

   row_type opening [18] = '{
      '{ptwbb_pkg::ACTION_REPORT,  32'hFFFF_FFFF, 6'd63, 16'hFFFF, 1'b1, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_MESSAGE, 32'd100,       6'd0,  16'd500,  1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_MESSAGE, 32'd100,       6'd0,  16'd1,    1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_MESSAGE, 32'd40,        6'd0,  16'd0,    1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_REPORT,  32'd0,         6'd0,  16'd0,    1'b1, 7'd1, 6'd0, 32'd2},
      '{ptwbb_pkg::ACTION_MESSAGE, 32'd101,       6'd63, 16'hFFFF, 1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_REPORT,  32'h5555_5555, 6'd42, 16'hAAAA, 1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_MESSAGE, 32'd101,       6'd63, 16'd0,    1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_MESSAGE, 32'd101,       6'd0,  16'd500,  1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_MESSAGE, 32'd101,       6'd0,  16'd1,    1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_MESSAGE, 32'd0,         6'd42, 16'h5555, 1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_MESSAGE, 32'd101,       6'd21, 16'd170,  1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_MESSAGE, 32'd101,       6'd21, 16'd330,  1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_MESSAGE, 32'd101,       6'd21, 16'd1,    1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_REPORT,  32'hAAAA_AAAA, 6'd21, 16'h5555, 1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_MESSAGE, 32'h7FFF_FFFF, 6'd0,  16'd250,  1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_MESSAGE, 32'h7FFF_FFFF, 6'd0,  16'd250,  1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_REPORT,  32'd0,         6'd0,  16'd0,    1'b0, 7'd0, 6'd0, 32'd0}
   };

   // The largest time opens the last window the block can ever open.
   row_type closing [4] = '{
      '{ptwbb_pkg::ACTION_MESSAGE, 32'hFFFF_FFFF, 6'd9,  16'd1,    1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_MESSAGE, 32'd0,         6'd9,  16'd0,    1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_MESSAGE, 32'hFFFF_FFFE, 6'd9,  16'd0,    1'b0, 7'd0, 6'd0, 32'd0},
      '{ptwbb_pkg::ACTION_REPORT,  32'hFFFF_FFFF, 6'd63, 16'hFFFF, 1'b0, 7'd0, 6'd0, 32'd0}
   };

   per_type_window_byte_budget DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_msg_time     (req_msg_time),
      .req_msg_type     (req_msg_type),
      .req_msg_size     (req_msg_size),
      .rsp_valid        (rsp_valid),
      .rsp_type_id      (rsp_type_id),
      .rsp_average      (rsp_average),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_budget_bytes (csr_budget_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      line_type due;
      if (!reset && rsp_valid) begin
         if (report_lines_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected report line: type %0d average %0d last %0b",
                        rsp_type_id, rsp_average, rsp_last);
         end else begin
            due = report_lines_due.pop_front();
            if (rsp_type_id !== due.type_id || rsp_average !== due.average ||
                rsp_last !== due.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("exp type %0d avg %0d last %0b, got type %0d avg %0d last %0b",
                           due.type_id, due.average, due.last,
                           rsp_type_id, rsp_average, rsp_last);
            end
         end
      end
   end

   initial begin
      for (int ty = 0; ty < NTYPES; ty++) begin
         seen_type[ty]      = 1'b0;
         used_in_window[ty] = 1'b0;
         bytes_left[ty]     = ptwbb_pkg::BUDGET_RESET;
         accepted_msgs[ty]  = '0;
         active_windows[ty] = '0;
      end
   end

   function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] count);
      bump = (count == ptwbb_pkg::COUNT_MAX) ? count : count + 1'b1;
   endfunction

   task automatic refill_budgets();
      for (int ty = 0; ty < NTYPES; ty++) begin
         bytes_left[ty]     = budget;
         used_in_window[ty] = 1'b0;
      end
   endtask

   task automatic charge_message(input logic [TIME_W-1:0] t, input logic [TYPE_W-1:0] ty,
                                 input logic [SIZE_W-1:0] size);
      if (!window_open) begin
         window_start = t;
         window_open  = 1'b1;
      end
      if (t > window_start) begin
         refill_budgets();
         window_start = t;
      end
      seen_type[ty] = 1'b1;
      if (size <= bytes_left[ty]) begin
         bytes_left[ty]    = bytes_left[ty] - size;
         accepted_msgs[ty] = bump(accepted_msgs[ty]);
         if (!used_in_window[ty]) begin
            active_windows[ty] = bump(active_windows[ty]);
            used_in_window[ty] = 1'b1;
         end
      end
   endtask

   task automatic list_averages();
      int       final_type;
      line_type line;
      final_type = -1;
      for (int ty = 0; ty < NTYPES; ty++)
         if (seen_type[ty])
            final_type = ty;
      for (int ty = 0; ty < NTYPES; ty++) begin
         if (seen_type[ty]) begin
            line.type_id = TYPE_W'(ty);
            line.average = (active_windows[ty] == 0) ? '0
                           : accepted_msgs[ty] / active_windows[ty];
            line.last    = (ty == final_type);
            report_lines_due.push_back(line);
         end
      end
   endtask

   task automatic issue(input logic act, input logic [TIME_W-1:0] t,
                        input logic [TYPE_W-1:0] ty, input logic [SIZE_W-1:0] size);
      start        <= 1'b1;
      req_action   <= act;
      req_msg_time <= t;
      req_msg_type <= ty;
      req_msg_size <= size;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic sender_gap();
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6))
            @(posedge clock);
      end
   endtask

   task automatic send(input logic act, input logic [TIME_W-1:0] t,
                       input logic [TYPE_W-1:0] ty, input logic [SIZE_W-1:0] size);
      issue(act, t, ty, size);
      if (act == ptwbb_pkg::ACTION_REPORT)
         list_averages();
      else
         charge_message(t, ty, size);
      sender_gap();
   endtask

   task automatic apply_row(input row_type row);
      line_type line;
      if (row.typed && row.action == ptwbb_pkg::ACTION_REPORT) begin
         issue(row.action, row.msg_time, row.msg_type, row.msg_size);
         if (row.lines == 1) begin
            line.type_id = row.line_type;
            line.average = row.line_average;
            line.last    = 1'b1;
            report_lines_due.push_back(line);
         end
         sender_gap();
      end else begin
         send(row.action, row.msg_time, row.msg_type, row.msg_size);
      end
   endtask

   task automatic hold_until_drained(input int extra);
      start <= 1'b0;
      @(posedge clock);
      while (report_lines_due.size() != 0)
         @(posedge clock);
      repeat (extra)
         @(posedge clock);
   endtask

   task automatic write_budget(input logic [SIZE_W-1:0] value);
      hold_until_drained(SETTLE);
      csr_valid        <= 1'b1;
      csr_budget_bytes <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      budget = value;
      if (!window_open)
         refill_budgets();
   endtask

   task automatic random_item();
      int                 pick;
      logic [TIME_W-1:0]  t;
      logic [TYPE_W-1:0]  ty;
      logic [SIZE_W-1:0]  size;
      if ($urandom_range(9) == 0) begin
         send(ptwbb_pkg::ACTION_REPORT, $urandom(), TYPE_W'($urandom()),
              SIZE_W'($urandom()));
      end else begin
         pick = $urandom_range(99);
         if (pick < 60)
            t = window_start;
         else if (pick < 85)
            t = window_start + $urandom_range(1, 3);
         else if (pick < 95)
            t = window_start - $urandom_range(0, 5000);
         else
            t = $urandom();
         ty = ($urandom_range(9) < 8) ? TYPE_W'($urandom_range(7))
                                      : TYPE_W'($urandom_range(NTYPES - 1));
         pick = $urandom_range(99);
         if (pick < 15)
            size = '0;
         else if (pick < 55)
            size = SIZE_W'($urandom_range(0, budget));
         else if (pick < 80)
            size = SIZE_W'($urandom_range(0, budget >> 2));
         else if (pick < 95)
            size = SIZE_W'($urandom_range(16'hFFFF));
         else
            size = 16'hFFFF;
         send(ptwbb_pkg::ACTION_MESSAGE, t, ty, size);
      end
   endtask

   initial begin
      repeat (2)
         @(posedge clock);
      reset <= 1'b0;
      write_budget(16'd500);
      idle_pct = 19;
      foreach (opening[i])
         apply_row(opening[i]);
      for (int seg = 0; seg < 6; seg++) begin
         idle_pct = (seg < 2) ? 19 : (seg < 4) ? 61 : 0;
         write_budget(segment_budget[seg]);
         for (int n = 0; n < 58; n++) begin
            if ($urandom_range(29) == 0)
               hold_until_drained(0);
            random_item();
         end
      end
      foreach (closing[i])
         apply_row(closing[i]);
      hold_until_drained(SETTLE);
      mismatches += report_lines_due.size();
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
